[hw/rtl/isr_pkg.sv]
// Shared widths and the cell record type for the integer square root block.
`default_nettype none

package isr_pkg;

    // Width of the radicand that the root is taken over; its top bit is the sign.
    localparam int DATA_WIDTH = 32;

    // Fixed widths of the request and response fields.
    localparam int IN_W  = 32;
    localparam int OUT_W = 16;

    // One root bit is settled per cell, so the row has ROOT_W cells.
    localparam int ROOT_W = (DATA_WIDTH + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Width that holds both the request field and the radicand.
    localparam int EXT_W = (DATA_WIDTH > IN_W) ? DATA_WIDTH : IN_W;

    // State handed from one cell to the next.
    typedef struct packed {
        logic              valid;
        logic              err;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } cell_t;

endpackage

`default_nettype wire

[hw/rtl/isr_in_if.sv]
// Request channel carrying the signed radicand.
`default_nettype none

interface isr_in_if;

    logic                           valid;
    logic                           ready;
    logic signed [isr_pkg::IN_W-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);

endinterface

`default_nettype wire

[hw/rtl/isr_out_if.sv]
// Response channel carrying the root and the domain error flag.
`default_nettype none

interface isr_out_if;

    logic                      valid;
    logic                      ready;
    logic [isr_pkg::OUT_W-1:0] square_root;
    logic                      domain_error;

    modport source (output valid, output square_root, output domain_error, input ready);
    modport sink   (input valid, input square_root, input domain_error, output ready);

endinterface

`default_nettype wire

[hw/rtl/integer_square_root_top.sv]
// Integer square root: a row of cells, one per root bit, followed by a response register.
//
// Each request carries a signed radicand; the response gives floor(sqrt(radicand)) and a
// domain error flag, which is set for a negative radicand while the root reads zero. The
// root is settled by the restoring bit-by-bit method in a row of ROOT_W identical cells,
// each fixing one root bit. The accepting edge writes the request into the first cell; it
// then moves on from cell to cell each time the row advances, and from the last cell into
// the response register, which offers the response. The whole row moves forward together
// whenever the response register is free or being emptied, so a new request is taken in
// every such cycle; while the response side stalls the row holds and no request is taken.
// Responses leave in the order their requests came in.
`default_nettype none

module integer_square_root_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    isr_in_if.sink    operand,
    isr_out_if.source result
);

    logic                          advance;
    logic [isr_pkg::EXT_W-1:0]     ext;
    logic                          sign;
    isr_pkg::cell_t                load;
    isr_pkg::cell_t                cells [isr_pkg::ROOT_W];

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [isr_pkg::OUT_W-1:0]     out_root_reg;
    logic [isr_pkg::OUT_W-1:0]     out_root_next;
    logic                          out_err_reg;
    logic                          out_err_next;

    // The row moves whenever the response register can take what leaves it.
    assign advance       = ~out_valid_reg | result.ready;
    assign operand.ready = advance;

    // Take the radicand from the request; a negative one enters the row as zero.
    always_comb
    begin
        ext        = isr_pkg::EXT_W'($unsigned(operand.radicand));
        sign       = ext[isr_pkg::DATA_WIDTH-1];
        load.valid = operand.valid & advance;
        load.err   = sign;
        load.rad   = sign ? '0 : isr_pkg::RAD_W'(ext[isr_pkg::DATA_WIDTH-1:0]);
        load.rem   = '0;
        load.root  = '0;
    end

    // Row of cells, one root bit each.
    for (genvar i = 0; i < isr_pkg::ROOT_W; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            isr_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .prev    (load),
                .hand_on (cells[i])
            );
        end
        else
        begin : g_rest
            isr_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .prev    (cells[i-1]),
                .hand_on (cells[i])
            );
        end
    end

    // Response register fed from the last cell.
    always_comb
    begin
        out_valid_next = cells[isr_pkg::ROOT_W-1].valid;
        out_root_next  = isr_pkg::OUT_W'(cells[isr_pkg::ROOT_W-1].root);
        out_err_next   = cells[isr_pkg::ROOT_W-1].err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_root_reg <= out_root_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.square_root  = out_root_reg;
    assign result.domain_error = out_err_reg;

    // A stalled response freezes the row; its first and last cells are checked.
    a_row_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cells[isr_pkg::ROOT_W-1]) && $stable(cells[0]))
        else $error("cell row moved while the response was stalled");

    // A domain error always comes with a zero root.
    a_err_zero_root : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.domain_error |-> result.square_root == '0)
        else $error("domain error response carries a non-zero root");

    // A negative radicand leaves nothing behind in the last cell.
    a_err_clean : assert property (@(posedge clk) disable iff (!rst_n)
        cells[isr_pkg::ROOT_W-1].valid && cells[isr_pkg::ROOT_W-1].err
            |-> cells[isr_pkg::ROOT_W-1].rem == '0 && cells[isr_pkg::ROOT_W-1].root == '0)
        else $error("negative radicand produced a non-zero remainder or root");

    // A request in the last cell shows up in the response register when the row advances.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        advance && cells[isr_pkg::ROOT_W-1].valid |=> result.valid)
        else $error("last cell's request did not reach the response register");

endmodule

`default_nettype wire

[hw/rtl/isr_cell.sv]
// One cell of the root row: settles one root bit and hands its state on.
`default_nettype none

module isr_cell
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire isr_pkg::cell_t prev,
    output isr_pkg::cell_t      hand_on
);

    logic                          valid_reg;
    logic                          valid_next;
    isr_pkg::cell_t                data_reg;
    isr_pkg::cell_t                data_next;
    logic [isr_pkg::REM_W-1:0]     rem_shift;
    logic [isr_pkg::REM_W:0]       trial;
    logic                          root_bit;

    // Bring down the next two radicand bits and try the trial subtraction.
    always_comb
    begin
        rem_shift  = {prev.rem[isr_pkg::REM_W-3:0], prev.rad[isr_pkg::RAD_W-1 -: 2]};
        trial      = {1'b0, rem_shift} - {1'b0, prev.root, 2'b01};
        root_bit   = ~trial[isr_pkg::REM_W];

        data_next       = prev;
        data_next.rad   = {prev.rad[isr_pkg::RAD_W-3:0], 2'b00};
        data_next.rem   = root_bit ? trial[isr_pkg::REM_W-1:0] : rem_shift;
        data_next.root  = {prev.root[isr_pkg::ROOT_W-2:0], root_bit};
        valid_next      = prev.valid;
    end

    // Occupancy flag of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Working values of the cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        hand_on       = data_reg;
        hand_on.valid = valid_reg;
    end

endmodule

`default_nettype wire
